// ===== rtl/bsws_pkg.sv =====
// ----------------------------------------------------------------------------
// bsws_pkg: shared types and constants
// Operation, status, cell shift and state codes for the search stack.
// ----------------------------------------------------------------------------
package bsws_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_POP    = 2'd1,
		MODE_DUMP   = 2'd2,
		MODE_SEARCH = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	// Move of the cell chain: keep, shift away from the top, shift toward it
	typedef enum logic [1:0] {
		SHIFT_HOLD = 2'd0,
		SHIFT_DOWN = 2'd1,
		SHIFT_UP   = 2'd2
	} shift_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'b01,
		FSM_SCAN = 2'b10
	} state_t;

	typedef logic signed [DATA_W-1:0] word_t;

endpackage

// ===== rtl/bsws_item_if.sv =====
// ----------------------------------------------------------------------------
// bsws_item_if: request channel
// Valid/ready channel carrying one stack operation and its operand.
// ----------------------------------------------------------------------------
interface bsws_item_if;
	import bsws_pkg::*;

	logic  valid;
	logic  ready;
	mode_t mode;
	word_t operand_value;

	modport source (output valid, output mode, output operand_value, input ready);
	modport sink (input valid, input mode, input operand_value, output ready);

endinterface

// ===== rtl/bsws_result_if.sv =====
// ----------------------------------------------------------------------------
// bsws_result_if: result channel
// Valid/ready channel carrying one status, data word, found flag and last mark.
// ----------------------------------------------------------------------------
interface bsws_result_if;
	import bsws_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	word_t   data_value;
	logic    found;
	logic    last_item;

	modport source (output valid, output status, output data_value, output found,
		output last_item, input ready);
	modport sink (input valid, input status, input data_value, input found,
		input last_item, output ready);

endinterface

// ===== rtl/bsws_cell.sv =====
// ----------------------------------------------------------------------------
// bsws_cell: one stack slot
// Holds one word and loads from its upper or lower neighbor on a shift.
// ----------------------------------------------------------------------------
module bsws_cell (
	input  logic             clk,
	input  bsws_pkg::shift_t cmd,
	input  bsws_pkg::word_t  up_data,
	input  bsws_pkg::word_t  down_data,
	output bsws_pkg::word_t  data
);
	import bsws_pkg::*;

	word_t data_q;

	// Take the neighbor's word on a shift, hold otherwise
	always_ff @(posedge clk) begin
		case (cmd)
			SHIFT_DOWN: data_q <= up_data;
			SHIFT_UP:   data_q <= down_data;
			SHIFT_HOLD: data_q <= data_q;
			default:    data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

// ===== rtl/bounded_stack_with_search_top.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_search_top: LIFO stack of signed words with search
// Chain of DEPTH cells, cell 0 the top of stack, with a one-result output.
// ----------------------------------------------------------------------------
// Usage:
//   item   : requests (mode, operand_value), taken when valid and ready.
//   result : status, data_value, found, last_item, one register deep.
//   Push and pop shift the whole chain one place and write their result
//   to the output register; a new request is taken in the next cycle if
//   the output register is free or being drained.
//   Dump and search rotate the chain through a full circle, one place per
//   step, reading cell 0 at each step; the circle brings every entry
//   back to its place. Dump gives one result per stored entry, top first,
//   last_item on the bottom one; search gives one result on its last step.
//   A pop, dump or search on an empty stack, or a push to a full one,
//   gives a single status result.
//   A dump or search takes no new request until its rotation ends, as
//   the single read port at cell 0 of the rotating chain serves each step.
//   When the receiver stalls with a result pending, the rotation and the
//   request side hold until the result is taken.
//   Reset empties the stack and drops any pending result; the cell words
//   are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_top #(
	parameter int DEPTH = 8
) (
	input  logic clk,
	input  logic arst_n,
	bsws_item_if.sink     item,
	bsws_result_if.source result
);
	import bsws_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = $clog2(DEPTH);

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [SW-1:0]   step_q;
	logic            dump_q;
	logic            hit_q;
	word_t           key_q;

	logic            out_valid_q;
	status_t         out_status_q;
	word_t           out_data_q;
	logic            out_found_q;
	logic            out_last_q;

	word_t           cell_q [DEPTH];
	shift_t          shift_cmd;

	logic            out_free;
	logic            accept;
	logic            scan_go;
	logic            in_range;
	logic            hit_now;
	logic            scan_end;

	logic            load_out;
	status_t         nx_status;
	word_t           nx_data;
	logic            nx_found;
	logic            nx_last;

	// Build the chain: cell 0 takes the operand on push, the top wraps to the bottom
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t up_w;
		word_t down_w;
		if (i == 0) begin : g_top
			assign up_w = item.operand_value;
		end else begin : g_mid
			assign up_w = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_bot
			assign down_w = cell_q[0];
		end else begin : g_up
			assign down_w = cell_q[i+1];
		end
		bsws_cell u_cell (
			.clk       (clk),
			.cmd       (shift_cmd),
			.up_data   (up_w),
			.down_data (down_w),
			.data      (cell_q[i])
		);
	end

	assign out_free   = !out_valid_q || result.ready;
	assign item.ready = (state_q == FSM_IDLE) && out_free;
	assign accept     = item.valid && item.ready;
	assign scan_go    = (state_q == FSM_SCAN) && out_free;
	assign in_range   = CW'(step_q) < count_q;
	assign hit_now    = hit_q || (in_range && (cell_q[0] == key_q));
	assign scan_end   = step_q == SW'(DEPTH - 1);

	// Decode the request or the scan step into a chain move and a result
	always_comb begin
		shift_cmd = SHIFT_HOLD;
		load_out  = 1'b0;
		nx_status = ST_OK;
		nx_data   = '0;
		nx_found  = 1'b0;
		nx_last   = 1'b1;
		if (accept) begin
			load_out = 1'b1;
			case (item.mode)
				MODE_PUSH: begin
					if (count_q == CW'(DEPTH)) begin
						nx_status = ST_OVERFLOW;
					end else begin
						shift_cmd = SHIFT_DOWN;
					end
				end
				MODE_POP: begin
					if (count_q == '0) begin
						nx_status = ST_EMPTY;
					end else begin
						shift_cmd = SHIFT_UP;
						nx_data   = cell_q[0];
					end
				end
				MODE_DUMP, MODE_SEARCH: begin
					if (count_q == '0) begin
						nx_status = ST_EMPTY;
					end else begin
						load_out = 1'b0;
					end
				end
				default: begin
					nx_status = ST_EMPTY;
				end
			endcase
		end else if (scan_go) begin
			shift_cmd = SHIFT_UP;
			if (dump_q) begin
				load_out = in_range;
				nx_data  = cell_q[0];
				nx_last  = CW'(step_q) == (count_q - CW'(1));
			end else begin
				load_out = scan_end;
				nx_found = hit_now;
			end
		end
	end

	// Track occupancy, scan progress and the running hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			count_q <= '0;
			step_q  <= '0;
			dump_q  <= 1'b0;
			hit_q   <= 1'b0;
		end else begin
			case (state_q)
				FSM_IDLE: begin
					if (accept) begin
						step_q <= '0;
						hit_q  <= 1'b0;
						dump_q <= item.mode == MODE_DUMP;
						if (item.mode == MODE_PUSH && count_q != CW'(DEPTH)) begin
							count_q <= count_q + CW'(1);
						end
						if (item.mode == MODE_POP && count_q != '0) begin
							count_q <= count_q - CW'(1);
						end
						if ((item.mode == MODE_DUMP || item.mode == MODE_SEARCH) &&
							count_q != '0) begin
							state_q <= FSM_SCAN;
						end
					end
				end
				FSM_SCAN: begin
					if (scan_go) begin
						hit_q  <= hit_now;
						step_q <= step_q + SW'(1);
						if (scan_end) begin
							state_q <= FSM_IDLE;
						end
					end
				end
				default: begin
					state_q <= FSM_IDLE;
				end
			endcase
		end
	end

	// Latch the key with each request
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= item.operand_value;
		end
	end

	// Hold the pending result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= nx_status;
			out_data_q   <= nx_data;
			out_found_q  <= nx_found;
			out_last_q   <= nx_last;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.status     = out_status_q;
	assign result.data_value = out_data_q;
	assign result.found      = out_found_q;
	assign result.last_item  = out_last_q;

endmodule

// ===== tb/bounded_stack_with_search_top_tb.sv =====
// ----------------------------------------------------------------------------
// bounded_stack_with_search_top_tb: self-checking bench for the search stack
// Drives push, pop, dump and search requests through the valid/ready request
// channel. A directed table covers the empty, full and extreme-value cases,
// then random requests follow. Every reply is checked against an in-bench
// stack predictor, with random idling on both channels and one long reply
// stall that backs the block up.
// ----------------------------------------------------------------------------
module bounded_stack_with_search_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bsws_pkg::*;

	localparam int DEPTH       = 8;
	localparam int RANDOM_REQS = 84;
	localparam int QUIET_REQS  = 20;
	localparam int LONG_HOLD   = 80;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_WAIT  = 4 * DEPTH;
	localparam int NUM_ROWS    = 26;

	typedef struct {
		status_t status;
		word_t   data_value;
		logic    found;
		logic    last_item;
	} reply_t;

	// One directed request; typed rows carry a status reply known up front
	typedef struct {
		mode_t   mode;
		word_t   operand;
		bit      typed;
		status_t exp_status;
	} dir_row_t;

	logic clk;
	logic arst_n;

	bsws_item_if   req_ch ();
	bsws_result_if rsp_ch ();

	bounded_stack_with_search_top #(
		.DEPTH(DEPTH)
	) uut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (req_ch),
		.result(rsp_ch)
	);

	// Predictor state: stack copy and replies still owed by the block
	word_t  stack_words [DEPTH];
	int     stack_fill;
	reply_t replies_due [$];

	int  fail_count     = 0;
	int  requests_sent  = 0;
	int  replies_seen   = 0;
	int  overflows_seen = 0;
	int  empties_seen   = 0;
	int  hits_seen      = 0;
	int  stall_cycles   = 0;
	bit  quiet_tail     = 1'b0;
	bit  hold_request   = 1'b0;
	bit  send_idle_on   = 1'b1;
	bit  recv_idle_on   = 1'b1;

	dir_row_t directed_rows [NUM_ROWS] = '{
		'{MODE_POP,    32'h00000000, 1'b1, ST_EMPTY},
		'{MODE_DUMP,   32'h00000000, 1'b1, ST_EMPTY},
		'{MODE_SEARCH, 32'h00000000, 1'b1, ST_EMPTY},
		'{MODE_PUSH,   32'h7FFFFFFF, 1'b0, ST_OK},
		'{MODE_PUSH,   32'h80000000, 1'b0, ST_OK},
		'{MODE_PUSH,   32'hFFFFFFFF, 1'b0, ST_OK},
		'{MODE_PUSH,   32'h00000000, 1'b0, ST_OK},
		'{MODE_SEARCH, 32'h80000000, 1'b0, ST_OK},
		'{MODE_SEARCH, 32'h00003039, 1'b0, ST_OK},
		'{MODE_PUSH,   32'h00000001, 1'b0, ST_OK},
		'{MODE_PUSH,   32'h55555555, 1'b0, ST_OK},
		'{MODE_PUSH,   32'hAAAAAAAA, 1'b0, ST_OK},
		'{MODE_PUSH,   32'h00000007, 1'b0, ST_OK},
		'{MODE_PUSH,   32'h00000063, 1'b1, ST_OVERFLOW},
		'{MODE_SEARCH, 32'h00000007, 1'b0, ST_OK},
		'{MODE_DUMP,   32'h00000000, 1'b0, ST_OK},
		'{MODE_POP,    32'h00000000, 1'b0, ST_OK},
		'{MODE_POP,    32'h00000000, 1'b0, ST_OK},
		'{MODE_POP,    32'h00000000, 1'b0, ST_OK},
		'{MODE_POP,    32'h00000000, 1'b0, ST_OK},
		'{MODE_POP,    32'h00000000, 1'b0, ST_OK},
		'{MODE_POP,    32'h00000000, 1'b0, ST_OK},
		'{MODE_DUMP,   32'h00000000, 1'b0, ST_OK},
		'{MODE_POP,    32'h00000000, 1'b0, ST_OK},
		'{MODE_POP,    32'h00000000, 1'b0, ST_OK},
		'{MODE_POP,    32'h00000000, 1'b1, ST_EMPTY}
	};

	// Clock: 4 ns period
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Apply one request to the stack copy and queue the replies it owes
	function automatic void apply_stack_op(input mode_t op, input word_t value);
		reply_t r;
		bit     hit;
		r   = '{status: ST_OK, data_value: '0, found: 1'b0, last_item: 1'b1};
		hit = 1'b0;
		case (op)
			MODE_PUSH: begin
				if (stack_fill >= DEPTH) begin
					r.status = ST_OVERFLOW;
				end else begin
					stack_words[stack_fill] = value;
					stack_fill++;
				end
				replies_due.push_back(r);
			end
			MODE_POP: begin
				if (stack_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					stack_fill--;
					r.data_value = stack_words[stack_fill];
				end
				replies_due.push_back(r);
			end
			MODE_DUMP: begin
				if (stack_fill == 0) begin
					r.status = ST_EMPTY;
					replies_due.push_back(r);
				end else begin
					for (int i = stack_fill - 1; i >= 0; i--) begin
						r.data_value = stack_words[i];
						r.last_item  = (i == 0);
						replies_due.push_back(r);
					end
				end
			end
			default: begin
				if (stack_fill == 0) begin
					r.status = ST_EMPTY;
				end else begin
					for (int i = 0; i < stack_fill; i++)
						if (stack_words[i] == value)
							hit = 1'b1;
					r.found = hit;
				end
				replies_due.push_back(r);
			end
		endcase
	endfunction

	// Operand mix: extremes, small values that repeat, full-range random
	function automatic word_t pick_operand();
		word_t v;
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 3))
					0: v = 32'h7FFFFFFF;
					1: v = 32'h80000000;
					2: v = 32'hFFFFFFFF;
					default: v = 32'h00000000;
				endcase
			end
			1, 2: v = word_t'($urandom_range(0, 15));
			default: v = word_t'($urandom());
		endcase
		return v;
	endfunction

	// Offer one request, with an optional idle burst first; return on acceptance
	task automatic offer_request(input mode_t op, input word_t value);
		if (!quiet_tail && send_idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid         <= 1'b1;
		req_ch.mode          <= op;
		req_ch.operand_value <= value;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		requests_sent++;
	endtask

	// Request side: reset, directed table, random phases, drain and verdict
	initial begin : request_side
		mode_t op;
		word_t value;
		int    roll;
		req_ch.valid         = 1'b0;
		req_ch.mode          = MODE_PUSH;
		req_ch.operand_value = '0;
		arst_n               = 1'b0;
		stack_fill           = 0;
		foreach (stack_words[i])
			stack_words[i] = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table; typed rows override the predicted reply
		foreach (directed_rows[k]) begin
			offer_request(directed_rows[k].mode, directed_rows[k].operand);
			apply_stack_op(directed_rows[k].mode, directed_rows[k].operand);
			if (directed_rows[k].typed)
				replies_due[replies_due.size() - 1] = '{status: directed_rows[k].exp_status,
					data_value: '0, found: 1'b0, last_item: 1'b1};
		end

		// Random part: alternate fill-biased and drain-biased phases
		hold_request = 1'b1;
		for (int k = 0; k < RANDOM_REQS; k++) begin
			if (k % 16 == 0)
				send_idle_on = 1'($urandom_range(0, 1));
			if (k == RANDOM_REQS - QUIET_REQS)
				quiet_tail = 1'b1;
			roll = $urandom_range(0, 99);
			if ((k / 15) % 2 == 0)
				op = (roll < 55) ? MODE_PUSH : (roll < 70) ? MODE_POP :
					(roll < 85) ? MODE_DUMP : MODE_SEARCH;
			else
				op = (roll < 20) ? MODE_PUSH : (roll < 70) ? MODE_POP :
					(roll < 85) ? MODE_DUMP : MODE_SEARCH;
			value = pick_operand();
			// Aim half the searches at a stored word so hits are common
			if (op == MODE_SEARCH && stack_fill > 0 && $urandom_range(0, 1) == 1)
				value = stack_words[$urandom_range(0, stack_fill - 1)];
			offer_request(op, value);
			apply_stack_op(op, value);
		end
		req_ch.valid <= 1'b0;

		// Drain outstanding replies, then watch for strays
		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Run covered %0d requests (%0d from the table) and %0d replies checked",
			requests_sent, NUM_ROWS, replies_seen);
		$display("  %0d overflow replies, %0d empty replies, %0d search hits",
			overflows_seen, empties_seen, hits_seen);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Reply side: random ready bursts, one long hold-off, none in the tail
	initial begin : reply_side
		int cyc;
		bit held;
		cyc          = 0;
		held         = 1'b0;
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 32 == 0)
				recv_idle_on = 1'($urandom_range(0, 1));
			if (hold_request && !held) begin
				held = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else if (!quiet_tail && recv_idle_on && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Compare each accepted reply with the oldest one owed
	always @(posedge clk) begin : reply_check
		reply_t due;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			replies_seen++;
			if (rsp_ch.status == ST_OVERFLOW)
				overflows_seen++;
			if (rsp_ch.status == ST_EMPTY)
				empties_seen++;
			if (rsp_ch.found === 1'b1)
				hits_seen++;
			if (replies_due.size() == 0) begin
				$error("reply with none owed: status %0d data_value %0d found %0b last_item %0b",
					rsp_ch.status, rsp_ch.data_value, rsp_ch.found, rsp_ch.last_item);
				fail_count++;
			end else begin
				due = replies_due.pop_front();
				if (rsp_ch.status !== due.status) begin
					$error("status: expected %0d, actual %0d", due.status, rsp_ch.status);
					fail_count++;
				end
				if (rsp_ch.data_value !== due.data_value) begin
					$error("data_value: expected %0d, actual %0d",
						due.data_value, rsp_ch.data_value);
					fail_count++;
				end
				if (rsp_ch.found !== due.found) begin
					$error("found: expected %0b, actual %0b", due.found, rsp_ch.found);
					fail_count++;
				end
				if (rsp_ch.last_item !== due.last_item) begin
					$error("last_item: expected %0b, actual %0b",
						due.last_item, rsp_ch.last_item);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves on either channel for too long
	always @(posedge clk) begin
		if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
			(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no request or reply moved for %0d cycles", STALL_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
